FILE: hw/rtl/psp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

    typedef struct packed {
        logic bvld;
        logic bfirst;
        logic bdat;
        logic mark;
        logic hit;
    } t_link;

endpackage

`default_nettype wire

FILE: hw/rtl/psp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module psp_cell
    import psp_pkg::*;
#(
    parameter int CELLS      = 16,
    parameter int VALUE_BITS = 16,
    parameter int IDX        = 0
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_link                           i_link,
    output t_link                                o_link,
    input  wire logic [$clog2(CELLS + 1) - 1:0]  i_used_cnt,
    input  wire logic                            i_wr_en,
    input  wire logic [VALUE_BITS - 1:0]         i_wr_value
);

    localparam int CW = $clog2(CELLS + 1);

    t_link                   r_link;
    t_link                   n_link;
    logic [VALUE_BITS - 1:0] r_rem;
    logic [VALUE_BITS - 1:0] n_rem;
    logic [VALUE_BITS - 1:0] r_prime;
    logic [VALUE_BITS:0]     w_shl;
    logic [VALUE_BITS:0]     w_red;
    logic                    w_used;

    assign w_used = (CW'(IDX) < i_used_cnt);

    always_comb begin
        w_shl = i_link.bfirst ? {{VALUE_BITS{1'b0}}, i_link.bdat} : {r_rem, i_link.bdat};
        if (w_shl >= {1'b0, r_prime}) begin
            w_red = w_shl - {1'b0, r_prime};
        end else begin
            w_red = w_shl;
        end
        n_rem = i_link.bvld ? w_red[VALUE_BITS - 1:0] : r_rem;
        n_link = i_link;
        n_link.hit = i_link.hit | (w_used && (r_rem == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if (i_wr_en && (i_used_cnt == CW'(IDX))) begin
            r_prime <= i_wr_value;
        end
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

FILE: hw/rtl/prime_sieve_pipeline.sv
`timescale 1ns / 1ps
`default_nettype none

// Prime sieve as a row of CELLS filter cells, one stored prime per cell. Each
// candidate on the slave stream (s_tlast marks end of stream and empties the
// row after that candidate) is shifted MSB first into the row and travels one
// cell per cycle; every cell reduces it bit-serially modulo its own prime and
// ORs its divisibility into a trailing mark token. One candidate is in flight
// at a time; the next one is taken only after the bit stream, the mark token,
// the trip of the mark down the row, its collection in S_WAIT and the retire
// in S_FIN, which for a prime waits while the output register is still full. A
// candidate of at least two that no stored prime divides is emitted on the
// master stream and stored in the next free cell; with the row full it is
// emitted with the not-stored flag in m_tuser and not kept. An output
// register lets the next candidate enter while a result waits to be taken.

module prime_sieve_pipeline
    import psp_pkg::*;
#(
    parameter int CELLS      = 16,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // value
    input  wire logic                                s_tlast,   // end_of_stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0]  m_tdata,   // prime
    output logic [0:0]                               m_tuser    // not_stored
);

    localparam int DW  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CW  = $clog2(CELLS + 1);
    localparam int BCW = $clog2(VALUE_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [CW - 1:0]  FULL     = CW'(CELLS);
    localparam logic [BCW - 1:0] LAST_BIT = BCW'(VALUE_BITS - 1);

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [BCW - 1:0]        r_cnt;
    logic [BCW - 1:0]        n_cnt;
    logic [VALUE_BITS - 1:0] r_shift;
    logic [VALUE_BITS - 1:0] n_shift;
    logic [VALUE_BITS - 1:0] r_value;
    logic [VALUE_BITS - 1:0] n_value;
    logic                    r_eos;
    logic                    n_eos;
    logic                    r_hit;
    logic                    n_hit;
    logic [CW - 1:0]         r_used;
    logic [CW - 1:0]         n_used;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic [VALUE_BITS - 1:0] r_out_data;
    logic [VALUE_BITS - 1:0] n_out_data;
    logic                    r_out_flag;
    logic                    n_out_flag;

    logic                    w_accept;
    logic                    w_prime;
    logic                    w_full;
    logic                    w_out_free;
    logic                    w_wr_en;
    t_link                   w_links [0:CELLS];

    assign s_tready   = (r_state == S_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    assign w_prime    = (r_value >= VALUE_BITS'(2)) && !r_hit;
    assign w_full     = (r_used == FULL);
    assign w_out_free = !r_out_valid || m_tready;
    assign w_wr_en    = (r_state == S_FIN) && w_prime && w_out_free && !w_full;

    always_comb begin
        w_links[0] = '0;
        if (r_state == S_SHIFT) begin
            w_links[0].bvld   = 1'b1;
            w_links[0].bfirst = (r_cnt == '0);
            w_links[0].bdat   = r_shift[VALUE_BITS - 1];
        end else if (r_state == S_MARK) begin
            w_links[0].mark = 1'b1;
        end
    end

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        psp_cell #(
            .CELLS      (CELLS),
            .VALUE_BITS (VALUE_BITS),
            .IDX        (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_link     (w_links[g]),
            .o_link     (w_links[g + 1]),
            .i_used_cnt (r_used),
            .i_wr_en    (w_wr_en),
            .i_wr_value (r_value)
        );
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_value     = r_value;
        n_eos       = r_eos;
        n_hit       = r_hit;
        n_used      = r_used;
        n_out_valid = r_out_valid && !m_tready;
        n_out_data  = r_out_data;
        n_out_flag  = r_out_flag;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_value = s_tdata[VALUE_BITS - 1:0];
                    n_shift = s_tdata[VALUE_BITS - 1:0];
                    n_eos   = s_tlast;
                    n_cnt   = '0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_shift = {r_shift[VALUE_BITS - 2:0], 1'b0};
                n_cnt   = r_cnt + BCW'(1);
                if (r_cnt == LAST_BIT) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_links[CELLS].mark) begin
                    n_hit   = w_links[CELLS].hit;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!w_prime) begin
                    if (r_eos) begin
                        n_used = '0;
                    end
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_value;
                    n_out_flag  = w_full;
                    if (!w_full) begin
                        n_used = r_used + CW'(1);
                    end
                    if (r_eos) begin
                        n_used = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_shift    <= n_shift;
        r_value    <= n_value;
        r_eos      <= n_eos;
        r_hit      <= n_hit;
        r_out_data <= n_out_data;
        r_out_flag <= n_out_flag;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = DW'(r_out_data);
    assign m_tuser  = r_out_flag;

endmodule

`default_nettype wire

FILE: hw/rtl/psp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module psp_checker #(
    parameter int VALUE_BITS = 16
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input wire logic [0:0]                          m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output transaction changed");

    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a candidate is in flight");

    a_prime_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((m_tdata[VALUE_BITS - 1:0] >= VALUE_BITS'(2))
                      && ((m_tdata >> VALUE_BITS) == '0)))
        else $error("emitted prime below two or padding not zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind prime_sieve_pipeline psp_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_psp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CELLS          = 16;
    localparam int VALUE_BITS     = 16;
    localparam int ITEM_TARGET    = 500;
    localparam int CALM_ITEMS     = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 150;
    localparam int LATENCY        = VALUE_BITS + CELLS + 3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [VALUE_BITS-1:0] prime;
        logic                  not_stored;
    } sieve_result_t;

    class sieve_scoreboard;
        logic [VALUE_BITS-1:0] stored_primes [CELLS];
        int unsigned           filled_cells;
        sieve_result_t         pending_q [$];
        int unsigned           mismatches;

        function new();
            filled_cells = 0;
            mismatches   = 0;
        endfunction

        function void note_candidate(logic [VALUE_BITS-1:0] value, logic eos);
            bit            divided;
            sieve_result_t res;
            int unsigned   i;
            divided = 1'b0;
            for (i = 0; i < filled_cells; i++) begin
                if (value % stored_primes[i] == 0) divided = 1'b1;
            end
            if (value >= 2 && !divided) begin
                res.prime      = value;
                res.not_stored = (filled_cells == CELLS);
                if (filled_cells < CELLS) begin
                    stored_primes[filled_cells] = value;
                    filled_cells++;
                end
                pending_q.push_back(res);
            end
            if (eos) filled_cells = 0;
        endfunction

        function void check_result(logic [VALUE_BITS-1:0] prime, logic not_stored);
            sieve_result_t want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected prime %0d not_stored %0b", prime, not_stored);
            end else begin
                want = pending_q.pop_front();
                if (want.prime !== prime || want.not_stored !== not_stored) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("prime mismatch: expected %0d/%0b, got %0d/%0b",
                                 want.prime, want.not_stored, prime, not_stored);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [VALUE_BITS-1:0] s_tdata;   // value
    logic                  s_tlast;   // end_of_stream
    logic                  m_tvalid;
    logic                  m_tready;
    logic [VALUE_BITS-1:0] m_tdata;   // prime
    logic [0:0]            m_tuser;   // not_stored

    sieve_scoreboard sb = new();

    int unsigned items_issued     = 0;
    int unsigned candidates_taken = 0;
    int unsigned stalled_cycles   = 0;
    bit          calm_tail        = 1'b0;
    bit          hold_done        = 1'b0;

    prime_sieve_pipeline #(
        .CELLS      (CELLS),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
            if (s_tvalid && s_tready) begin
                sb.note_candidate(s_tdata, s_tlast);
                candidates_taken++;
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
                if (stalled_cycles >= WATCHDOG_LIMIT) begin
                    $display("prime_sieve_pipeline test failed");
                    $finish;
                end
            end
        end
    end

    // Hold off once for a long stretch so the row backs up to the input.
    initial begin
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && candidates_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_tready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge i_clk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Call at a falling edge; return at the falling edge after the transaction.
    task automatic send_candidate(input logic [VALUE_BITS-1:0] value, input logic eos);
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        s_tlast  = eos;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (value >= 2) items_issued++;
        calm_tail = (items_issued >= ITEM_TARGET - CALM_ITEMS);
    endtask

    task automatic send_sieve_run();
        int unsigned len;
        int unsigned k;
        int unsigned value;
        int unsigned next_value;
        int unsigned jump_odds;
        int unsigned jump_max;
        bit          close_run;
        len       = $urandom_range(5, 90);
        close_run = ($urandom_range(0, 4) != 0);
        jump_odds = ($urandom_range(0, 4) == 0) ? 1 : 9;
        jump_max  = (jump_odds == 1) ? 8000 : 4000;
        value     = 2;
        k         = 0;
        while (k < len && value <= 16'hFFFF) begin
            next_value = ($urandom_range(0, jump_odds) == 0) ?
                         value + $urandom_range(2, jump_max) : value + 1;
            send_candidate(value[VALUE_BITS-1:0],
                           close_run && (k == len - 1 || next_value > 16'hFFFF));
            value = next_value;
            k++;
        end
    endtask

    task automatic send_noise();
        int unsigned count;
        int unsigned k;
        count = $urandom_range(1, 8);
        for (k = 0; k < count; k++)
            send_candidate(VALUE_BITS'($urandom_range(0, 16'hFFFF)),
                           $urandom_range(0, 3) == 0);
    endtask

    initial begin
        int unsigned v;
        int unsigned d;
        bit          composite;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_candidate(16'd0, 1'b0);
        send_candidate(16'd1, 1'b1);
        send_candidate(16'd2, 1'b0);
        send_candidate(16'd2, 1'b0);
        send_candidate(16'd4, 1'b1);
        send_candidate(16'd4, 1'b0);
        send_candidate(16'hFFFF, 1'b1);
        // fill every cell, then overflow the row
        for (v = 2; v <= 53; v++) begin
            composite = 1'b0;
            for (d = 2; d < v; d++) begin
                if (v % d == 0) composite = 1'b1;
            end
            if (!composite) send_candidate(v[VALUE_BITS-1:0], 1'b0);
        end
        send_candidate(16'd65521, 1'b0);
        send_candidate(16'd59, 1'b1);

        while (items_issued < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0) send_noise();
            else send_sieve_run();
        end
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("prime_sieve_pipeline test passed");
        end else begin
            $display("prime_sieve_pipeline test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/psp_pkg.sv
hw/rtl/psp_cell.sv
hw/rtl/prime_sieve_pipeline.sv
hw/rtl/psp_checker.sv
sim/tb_top.sv
